### design/fsc_pkg.sv
// Package for the falling-sand cell update block: field widths, codes and state types.
`default_nettype none
package fsc_pkg;

  // Fixed payload field widths
  localparam int unsigned CMD_W = 2;
  localparam int unsigned POS_W = 6;
  localparam int unsigned VAL_W = 8;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SAND   = 2'd2,
    CMD_LIQUID = 2'd3
  } fsc_cmd_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_READ_WAIT,
    ST_PROBE,
    ST_CHECK,
    ST_MV_RD,
    ST_MV_CLR,
    ST_MV_WR,
    ST_RESULT
  } fsc_state_e;

  // Neighbor probes, in the order the rules try them
  typedef enum logic [2:0] {
    STEP_DOWN,
    STEP_DIAG1_LOW,
    STEP_DIAG1_SIDE,
    STEP_DIAG2_LOW,
    STEP_DIAG2_SIDE,
    STEP_SLIDE1,
    STEP_SLIDE2
  } fsc_step_e;

  // Column offset of a probe
  typedef enum logic [1:0] {
    OFS_ZERO,
    OFS_PLUS,
    OFS_MINUS
  } fsc_ofs_e;

endpackage
`default_nettype wire

### design/fsc_in_if.sv
// Command channel interface: valid/ready plus one command item.
`default_nettype none
interface fsc_in_if;
  import fsc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] x_pos;
  logic [POS_W-1:0] y_pos;
  logic [VAL_W-1:0] cell_value;
  logic             diag_left;
  logic             side_left;

  modport source (
    output valid, command, x_pos, y_pos, cell_value, diag_left, side_left,
    input  ready
  );

  modport sink (
    input  valid, command, x_pos, y_pos, cell_value, diag_left, side_left,
    output ready
  );

endinterface
`default_nettype wire

### design/fsc_out_if.sv
// Result channel interface: valid/ready plus one result item.
`default_nettype none
interface fsc_out_if;
  import fsc_pkg::*;

  logic             valid;
  logic             ready;
  logic             moved;
  logic [POS_W-1:0] dest_x;
  logic [POS_W-1:0] dest_y;
  logic [VAL_W-1:0] read_value;

  modport source (
    output valid, moved, dest_x, dest_y, read_value,
    input  ready
  );

  modport sink (
    input  valid, moved, dest_x, dest_y, read_value,
    output ready
  );

endinterface
`default_nettype wire

### design/falling_sand_cell_update.sv
// Top level of the falling-sand cell update block: sequencer, cell store and probe unit.
//
//  channel  | dir | handshake     | item
//  ---------+-----+---------------+--------------------------------------------------
//  in_i     | in  | valid / ready | command, x_pos, y_pos, cell_value, diag/side_left
//  out_o    | out | valid / ready | moved, dest_x, dest_y, read_value
//
// Every memory access goes through one single-port store, so each neighbor probe takes
// a probe state (address) and a check state (registered data), only the first when the
// target is off the grid. A write passes dispatch and result, a read also a data wait;
// a step adds its probes (up to five for sand), a move its read, clear and write states.
// A liquid slide probes once per cell it passes. After reset the store is zeroed one
// cell a cycle, during which no item is taken. A finished result waits in the output
// register as the next item is taken; the block stalls only with a second result ready.
`default_nettype none
module falling_sand_cell_update #(
  parameter int unsigned GRID_WIDTH   = 64,
  parameter int unsigned GRID_HEIGHT  = 64,
  parameter int unsigned CELL_ID_BITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fsc_in_if.sink    in_i,
  fsc_out_if.source out_o
);
  import fsc_pkg::*;

  localparam int unsigned CW    = (GRID_WIDTH > 64) ? $clog2(GRID_WIDTH) : POS_W;
  localparam int unsigned RW    = (GRID_HEIGHT > 64) ? $clog2(GRID_HEIGHT) : POS_W;
  localparam int unsigned DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = CELL_ID_BITS;
  localparam logic [RW-1:0] HLAST = RW'(GRID_HEIGHT - 1);

  fsc_state_e state_q, state_d;
  fsc_step_e  step_q, step_d;
  fsc_cmd_e   cmd_q;

  logic [CW-1:0]    x_q, cur_x_q, cur_x_d, dst_x_q, dst_x_d;
  logic [RW-1:0]    y_q, dst_y_q, dst_y_d;
  logic [DW-1:0]    data_q, data_d;
  logic             d1_left_q, s1_left_q;
  logic             moved_q, moved_d;
  logic [VAL_W-1:0] rd_q, rd_d;

  // Output register
  logic             out_valid_q;
  logic             out_moved_q;
  logic [POS_W-1:0] out_dx_q, out_dy_q;
  logic [VAL_W-1:0] out_rd_q;
  logic             out_load;

  // Probe unit
  logic [CW-1:0] pg_col_in, pg_col;
  logic [RW-1:0] pg_row_in, pg_row;
  fsc_ofs_e      pg_ofs;
  logic          pg_down;
  logic          pg_in_grid;
  logic [AW-1:0] pg_addr;

  // Store port
  logic          ram_we, ram_re, ram_busy;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  // Decisions
  logic          probe_done, probe_empty, slid, is_liquid;
  logic          go_move, go_fail, cap_dst, adv, cur_reset;
  fsc_ofs_e      d1_ofs, d2_ofs, sl_ofs;
  logic [DW+VAL_W-1:0] val_wide;
  logic [DW+VAL_W-1:0] rd_wide;

  // Id width adaption
  assign val_wide = {{DW{1'b0}}, in_i.cell_value};
  assign rd_wide  = {{VAL_W{1'b0}}, ram_rdata};

  fsc_probe #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT),
    .CW          (CW),
    .RW          (RW),
    .AW          (AW)
  ) u_probe (
    .col_i     (pg_col_in),
    .row_i     (pg_row_in),
    .ofs_x_i   (pg_ofs),
    .down_i    (pg_down),
    .col_o     (pg_col),
    .row_o     (pg_row),
    .in_grid_o (pg_in_grid),
    .addr_o    (pg_addr)
  );

  fsc_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata),
    .busy_o  (ram_busy)
  );

  // Probe direction codes
  assign d1_ofs    = d1_left_q ? OFS_MINUS : OFS_PLUS;
  assign d2_ofs    = d1_left_q ? OFS_PLUS : OFS_MINUS;
  assign sl_ofs    = ((step_q == STEP_SLIDE1) == s1_left_q) ? OFS_MINUS : OFS_PLUS;
  assign is_liquid = (cmd_q == CMD_LIQUID);
  assign slid      = (cur_x_q != x_q);

  // Probe unit input select
  always_comb begin
    pg_col_in = x_q;
    pg_row_in = y_q;
    pg_ofs    = OFS_ZERO;
    pg_down   = 1'b0;
    case (state_q)
      ST_MV_WR: begin
        pg_col_in = dst_x_q;
        pg_row_in = dst_y_q;
      end
      ST_PROBE, ST_CHECK: begin
        case (step_q)
          STEP_DOWN: pg_down = 1'b1;
          STEP_DIAG1_LOW: begin
            pg_ofs  = d1_ofs;
            pg_down = 1'b1;
          end
          STEP_DIAG1_SIDE: pg_ofs = d1_ofs;
          STEP_DIAG2_LOW: begin
            pg_ofs  = d2_ofs;
            pg_down = 1'b1;
          end
          STEP_DIAG2_SIDE: pg_ofs = d2_ofs;
          STEP_SLIDE1, STEP_SLIDE2: begin
            pg_col_in = cur_x_q;
            pg_ofs    = sl_ofs;
          end
          default: pg_down = 1'b0;
        endcase
      end
      default: pg_down = 1'b0;
    endcase
  end

  // Probe outcome: off-grid decides at once, otherwise on the returned id
  assign probe_done  = ((state_q == ST_PROBE) && !pg_in_grid) || (state_q == ST_CHECK);
  assign probe_empty = (state_q == ST_CHECK) && (ram_rdata == '0);

  // Rule decisions
  always_comb begin
    step_d    = step_q;
    go_move   = 1'b0;
    go_fail   = 1'b0;
    cap_dst   = 1'b0;
    adv       = 1'b0;
    cur_reset = 1'b0;
    if (probe_done) begin
      case (step_q)
        STEP_DOWN: begin
          if (probe_empty) begin
            cap_dst = 1'b1;
            go_move = 1'b1;
          end else begin
            step_d = STEP_DIAG1_LOW;
          end
        end
        STEP_DIAG1_LOW: begin
          if (probe_empty) begin
            cap_dst = 1'b1;
            if (is_liquid) go_move = 1'b1;
            else step_d = STEP_DIAG1_SIDE;
          end else begin
            step_d = STEP_DIAG2_LOW;
          end
        end
        STEP_DIAG1_SIDE: begin
          if (probe_empty) go_move = 1'b1;
          else step_d = STEP_DIAG2_LOW;
        end
        STEP_DIAG2_LOW: begin
          if (probe_empty) begin
            cap_dst = 1'b1;
            if (is_liquid) go_move = 1'b1;
            else step_d = STEP_DIAG2_SIDE;
          end else if (is_liquid) begin
            step_d    = STEP_SLIDE1;
            cur_reset = 1'b1;
          end else begin
            go_fail = 1'b1;
          end
        end
        STEP_DIAG2_SIDE: begin
          if (probe_empty) go_move = 1'b1;
          else go_fail = 1'b1;
        end
        STEP_SLIDE1: begin
          if (probe_empty) begin
            adv     = 1'b1;
            cap_dst = 1'b1;
          end else if (slid) begin
            go_move = 1'b1;
          end else begin
            step_d    = STEP_SLIDE2;
            cur_reset = 1'b1;
          end
        end
        STEP_SLIDE2: begin
          if (probe_empty) begin
            adv     = 1'b1;
            cap_dst = 1'b1;
          end else if (slid) begin
            go_move = 1'b1;
          end else begin
            go_fail = 1'b1;
          end
        end
        default: go_fail = 1'b1;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (!ram_busy) state_d = ST_IDLE;
      ST_IDLE:  if (in_i.valid) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (cmd_q)
          CMD_READ:   state_d = pg_in_grid ? ST_READ_WAIT : ST_RESULT;
          CMD_SAND:   state_d = (pg_in_grid && (y_q != HLAST)) ? ST_PROBE : ST_RESULT;
          CMD_LIQUID: state_d = pg_in_grid ? ST_PROBE : ST_RESULT;
          default:    state_d = ST_RESULT;
        endcase
      end
      ST_READ_WAIT: state_d = ST_RESULT;
      ST_PROBE: begin
        // a slide that runs into the grid edge ends its move here
        if (!pg_in_grid) begin
          if (go_move) state_d = ST_MV_RD;
          else if (go_fail) state_d = ST_RESULT;
          else state_d = ST_PROBE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (go_move) state_d = ST_MV_RD;
        else if (go_fail) state_d = ST_RESULT;
        else state_d = ST_PROBE;
      end
      ST_MV_RD:  state_d = ST_MV_CLR;
      ST_MV_CLR: state_d = ST_MV_WR;
      ST_MV_WR:  state_d = ST_RESULT;
      ST_RESULT: if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Store port and datapath updates
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = pg_addr;
    ram_wdata = data_q;
    data_d    = data_q;
    moved_d   = moved_q;
    rd_d      = rd_q;
    cur_x_d   = cur_x_q;
    dst_x_d   = dst_x_q;
    dst_y_d   = dst_y_q;
    case (state_q)
      ST_DISPATCH: begin
        moved_d = 1'b0;
        rd_d    = '0;
        cur_x_d = x_q;
        if ((cmd_q == CMD_WRITE) && pg_in_grid) ram_we = 1'b1;
        if ((cmd_q == CMD_READ) && pg_in_grid) ram_re = 1'b1;
      end
      ST_READ_WAIT: rd_d = rd_wide[VAL_W-1:0];
      ST_PROBE: ram_re = pg_in_grid;
      ST_MV_RD: ram_re = 1'b1;
      ST_MV_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        data_d    = ram_rdata;
      end
      ST_MV_WR: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
    if (cap_dst) begin
      dst_x_d = pg_col;
      dst_y_d = pg_row;
    end
    if (adv) cur_x_d = pg_col;
    if (cur_reset) cur_x_d = x_q;
    if (go_move) moved_d = 1'b1;
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_RESULT) && (!out_valid_q || out_o.ready);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Item and working registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q     <= fsc_cmd_e'(in_i.command);
      x_q       <= CW'(in_i.x_pos);
      y_q       <= RW'(in_i.y_pos);
      data_q    <= val_wide[DW-1:0];
      d1_left_q <= in_i.diag_left;
      s1_left_q <= in_i.side_left;
    end else begin
      data_q <= data_d;
    end
    step_q  <= (state_q == ST_DISPATCH) ? STEP_DOWN : step_d;
    moved_q <= moved_d;
    rd_q    <= rd_d;
    cur_x_q <= cur_x_d;
    dst_x_q <= dst_x_d;
    dst_y_q <= dst_y_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_moved_q <= moved_q;
      out_dx_q    <= moved_q ? POS_W'(dst_x_q) : '0;
      out_dy_q    <= moved_q ? POS_W'(dst_y_q) : '0;
      out_rd_q    <= rd_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.moved      = out_moved_q;
  assign out_o.dest_x     = out_dx_q;
  assign out_o.dest_y     = out_dy_q;
  assign out_o.read_value = out_rd_q;

  // The single store port is never read and written in one cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("cell store read and written in the same cycle");

  // A data check only follows a probe issued inside the grid
  a_check_after_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> $past((state_q == ST_PROBE) && pg_in_grid))
    else $error("probe check without an in-grid probe");

  // A new result is only loaded from the result state
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result presented outside the result state");

  // A result carries either read data or a move, never both
  a_read_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_rd_q != '0)) |-> !out_moved_q)
    else $error("result reports a move and read data together");

endmodule
`default_nettype wire

### design/fsc_cell_ram.sv
// Single-port cell store with registered read and a zeroing sweep after reset.
`default_nettype none
module fsc_cell_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o,
  output logic               busy_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_idx_q, clr_idx_d;
  logic          busy_q, busy_d;
  logic [DW-1:0] rdata_q;

  // Sweep counter: one entry per cycle until the last one is zeroed
  always_comb begin
    clr_idx_d = clr_idx_q;
    busy_d    = busy_q;
    if (busy_q) begin
      if (clr_idx_q == AW'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_idx_q <= clr_idx_d;
      busy_q    <= busy_d;
    end
  end

  // Array write: sweep has priority, the sequencer is held off meanwhile
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule
`default_nettype wire

### design/fsc_probe.sv
// Shared neighbor unit: applies a column/row offset, checks the grid bounds, forms the address.
`default_nettype none
module fsc_probe #(
  parameter int unsigned GRID_WIDTH  = 64,
  parameter int unsigned GRID_HEIGHT = 64,
  parameter int unsigned CW          = 6,
  parameter int unsigned RW          = 6,
  parameter int unsigned AW          = 12
) (
  input  wire logic              [CW-1:0] col_i,
  input  wire logic              [RW-1:0] row_i,
  input  wire fsc_pkg::fsc_ofs_e          ofs_x_i,
  input  wire logic                       down_i,
  output logic                   [CW-1:0] col_o,
  output logic                   [RW-1:0] row_o,
  output logic                            in_grid_o,
  output logic                   [AW-1:0] addr_o
);
  import fsc_pkg::*;

  localparam logic [CW:0]   WLIM  = (CW+1)'(GRID_WIDTH);
  localparam logic [RW:0]   HLIM  = (RW+1)'(GRID_HEIGHT);
  localparam logic [CW-1:0] WLAST = CW'(GRID_WIDTH - 1);
  localparam logic [RW-1:0] HLAST = RW'(GRID_HEIGHT - 1);
  localparam logic [AW-1:0] WMUL  = AW'(GRID_WIDTH);

  logic base_ok;
  logic col_edge;
  logic row_edge;

  // Target coordinate
  always_comb begin
    case (ofs_x_i)
      OFS_PLUS:  col_o = col_i + CW'(1);
      OFS_MINUS: col_o = col_i - CW'(1);
      default:   col_o = col_i;
    endcase
    row_o = down_i ? row_i + RW'(1) : row_i;
  end

  // Bounds: base inside, and the step does not cross an edge
  assign base_ok   = ({1'b0, col_i} < WLIM) && ({1'b0, row_i} < HLIM);
  assign col_edge  = ((ofs_x_i == OFS_MINUS) && (col_i == '0)) ||
                     ((ofs_x_i == OFS_PLUS) && (col_i == WLAST));
  assign row_edge  = down_i && (row_i == HLAST);
  assign in_grid_o = base_ok && !col_edge && !row_edge;

  // Row-major address
  assign addr_o = AW'(row_o) * WMUL + AW'(col_o);

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the falling-sand cell update block, with a tracked copy of the grid.
`timescale 1ns / 1ps
module testbench;
  import fsc_pkg::*;

  localparam int GRID_W       = 64;
  localparam int GRID_H       = 64;
  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_CYCLES = 300;      // longer than the slowest liquid slide
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int LONG_HOLD    = 600;      // one long result stall, fills the block
  localparam int HOLD_AT      = 200;      // result count at which that stall starts

  typedef struct packed {
    fsc_cmd_e         command;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [VAL_W-1:0] cell_value;
    logic             diag_left;
    logic             side_left;
  } command_t;

  typedef struct packed {
    logic             moved;
    logic [POS_W-1:0] dest_x;
    logic [POS_W-1:0] dest_y;
    logic [VAL_W-1:0] read_value;
  } outcome_t;

  // Tracks the grid contents and the outcomes still owed by the block
  class cell_grid_tracker;
    bit [VAL_W-1:0] cells [GRID_H][GRID_W];   // zero after reset: all empty
    outcome_t       expected_outcomes [$];
    int             mismatches;

    function bit vacant(int x, int y);
      if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) return 1'b0;
      return cells[y][x] == '0;
    endfunction

    // Farthest column of the empty run next to (x, y) in direction d
    function int run_end(int x, int y, int d);
      int cx;
      cx = x;
      while (vacant(cx + d, y)) cx += d;
      return cx;
    endfunction

    function outcome_t predict_outcome(command_t c);
      outcome_t   r;
      int         x, y, d1, s1, tx, ty;
      bit         mv;
      bit [VAL_W-1:0] id;
      r  = '0;
      x  = int'(c.x_pos);
      y  = int'(c.y_pos);
      d1 = c.diag_left ? -1 : 1;
      s1 = c.side_left ? -1 : 1;
      mv = 1'b0;
      tx = 0;
      ty = 0;
      case (c.command)
        CMD_WRITE: cells[y][x] = c.cell_value;
        CMD_READ:  r.read_value = cells[y][x];
        CMD_SAND: begin
          // bottom row never moves; diagonals also need the side cell empty
          if (y != GRID_H - 1) begin
            if (cells[y+1][x] == '0) begin
              mv = 1'b1; tx = x; ty = y + 1;
            end else if (vacant(x + d1, y + 1) && vacant(x + d1, y)) begin
              mv = 1'b1; tx = x + d1; ty = y + 1;
            end else if (vacant(x - d1, y + 1) && vacant(x - d1, y)) begin
              mv = 1'b1; tx = x - d1; ty = y + 1;
            end
          end
        end
        CMD_LIQUID: begin
          if (vacant(x, y + 1)) begin
            mv = 1'b1; tx = x; ty = y + 1;
          end else if (vacant(x + d1, y + 1)) begin
            mv = 1'b1; tx = x + d1; ty = y + 1;
          end else if (vacant(x - d1, y + 1)) begin
            mv = 1'b1; tx = x - d1; ty = y + 1;
          end else begin
            // slide along the row, first side then the other
            tx = run_end(x, y, s1);
            if (tx == x) tx = run_end(x, y, -s1);
            if (tx != x) begin
              mv = 1'b1; ty = y;
            end
          end
        end
        default: ;
      endcase
      if (mv) begin
        id = cells[y][x];
        cells[y][x] = '0;
        cells[ty][tx] = id;
        r.moved  = 1'b1;
        r.dest_x = POS_W'(tx);
        r.dest_y = POS_W'(ty);
      end
      return r;
    endfunction

    function void take_command(command_t c);
      expected_outcomes.push_back(predict_outcome(c));
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result arrived with no command outstanding");
        mismatches++;
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.moved !== want.moved) begin
        $error("moved: expected %0d, got %0d", want.moved, got.moved);
        mismatches++;
      end
      if (got.dest_x !== want.dest_x) begin
        $error("dest_x: expected %0d, got %0d", want.dest_x, got.dest_x);
        mismatches++;
      end
      if (got.dest_y !== want.dest_y) begin
        $error("dest_y: expected %0d, got %0d", want.dest_y, got.dest_y);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fsc_in_if  cmd_bus ();
  fsc_out_if res_bus ();

  falling_sand_cell_update dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_bus),
    .out_o  (res_bus)
  );

  cell_grid_tracker grid;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Offer one command item and wait until it is taken
  task automatic send_command(fsc_cmd_e cmd, int x, int y, int value, bit dl, bit sl);
    int       gap;
    command_t c;
    c.command    = cmd;
    c.x_pos      = POS_W'(x);
    c.y_pos      = POS_W'(y);
    c.cell_value = VAL_W'(value);
    c.diag_left  = dl;
    c.side_left  = sl;
    gap = send_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= c.command;
    cmd_bus.x_pos      <= c.x_pos;
    cmd_bus.y_pos      <= c.y_pos;
    cmd_bus.cell_value <= c.cell_value;
    cmd_bus.diag_left  <= c.diag_left;
    cmd_bus.side_left  <= c.side_left;
    do @(posedge clk_i); while (!cmd_bus.ready);
    grid.take_command(c);
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
  endtask

  function automatic int pick_base();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return GRID_W - 6;
      default: return $urandom_range(0, GRID_W - 6);
    endcase
  endfunction

  // Result side: random stalls plus one long hold-off
  initial begin : result_sink
    int       hold;
    int       taken;
    outcome_t got;
    taken = 0;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = recv_steady ? 0 : $urandom_range(0, 9);
      if (taken == HOLD_AT) hold = LONG_HOLD;
      if (hold > 0) begin
        res_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_bus.valid && res_bus.ready));
      got.moved      = res_bus.moved;
      got.dest_x     = res_bus.dest_x;
      got.dest_y     = res_bus.dest_y;
      got.read_value = res_bus.read_value;
      grid.check_outcome(got);
      taken++;
      if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
    end
  end

  initial begin : stimulus
    int       bx, by, x, y, pick, value;
    fsc_cmd_e cmd;
    grid = new();
    rst_ni             <= 1'b0;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.command    <= CMD_WRITE;
    cmd_bus.x_pos      <= '0;
    cmd_bus.y_pos      <= '0;
    cmd_bus.cell_value <= '0;
    cmd_bus.diag_left  <= 1'b0;
    cmd_bus.side_left  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corner writes and reads, bottom row
    send_command(CMD_WRITE, 0, 0, 255, 1'b0, 1'b0);
    send_command(CMD_READ, 0, 0, 0, 1'b0, 1'b0);
    send_command(CMD_WRITE, 63, 63, 1, 1'b1, 1'b1);
    send_command(CMD_READ, 63, 63, 0, 1'b1, 1'b1);
    send_command(CMD_SAND, 63, 63, 0, 1'b0, 1'b0);
    send_command(CMD_SAND, 0, 0, 0, 1'b0, 1'b0);
    // empty cell still moves
    send_command(CMD_SAND, 10, 10, 0, 1'b1, 1'b0);
    // sand: first diagonal free
    send_command(CMD_WRITE, 20, 62, 5, 1'b0, 1'b0);
    send_command(CMD_WRITE, 20, 63, 6, 1'b0, 1'b0);
    send_command(CMD_SAND, 20, 62, 0, 1'b1, 1'b0);
    // sand: first diagonal target taken, falls the other way
    send_command(CMD_WRITE, 30, 62, 7, 1'b0, 1'b0);
    send_command(CMD_WRITE, 30, 63, 8, 1'b0, 1'b0);
    send_command(CMD_WRITE, 29, 63, 9, 1'b0, 1'b0);
    send_command(CMD_SAND, 30, 62, 0, 1'b1, 1'b0);
    // sand: side cell blocks the first diagonal
    send_command(CMD_WRITE, 40, 62, 3, 1'b0, 1'b0);
    send_command(CMD_WRITE, 40, 63, 3, 1'b0, 1'b0);
    send_command(CMD_WRITE, 41, 62, 3, 1'b0, 1'b0);
    send_command(CMD_SAND, 40, 62, 0, 1'b0, 1'b0);
    // liquid on the bottom row: a grid edge on the first slide side forces the other side
    send_command(CMD_LIQUID, 63, 63, 0, 1'b0, 1'b0);
    send_command(CMD_LIQUID, 0, 63, 0, 1'b1, 1'b1);
    // liquid boxed in on both sides
    send_command(CMD_WRITE, 49, 63, 4, 1'b0, 1'b0);
    send_command(CMD_WRITE, 51, 63, 4, 1'b0, 1'b0);
    send_command(CMD_LIQUID, 50, 63, 0, 1'b1, 1'b0);
    // liquid diagonal
    send_command(CMD_LIQUID, 29, 62, 0, 1'b1, 1'b1);

    // Random: clusters of activity in small windows so cells pile up
    bx = 0;
    by = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 25 == 0) begin
        bx = pick_base();
        by = pick_base();
      end
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom_range(0, GRID_W - 1);
        y = $urandom_range(0, GRID_H - 1);
      end else begin
        x = bx + $urandom_range(0, 5);
        y = by + $urandom_range(0, 5);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)      cmd = CMD_WRITE;
      else if (pick < 55) cmd = CMD_READ;
      else if (pick < 80) cmd = CMD_SAND;
      else                cmd = CMD_LIQUID;
      value = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 255);
      send_command(cmd, x, y, value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    cmd_bus.valid <= 1'b0;

    // Drain and watch for stray results
    while (grid.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (grid.mismatches == 0 && grid.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
design/fsc_pkg.sv
design/fsc_in_if.sv
design/fsc_out_if.sv
design/fsc_cell_ram.sv
design/fsc_probe.sv
design/falling_sand_cell_update.sv
tb/testbench.sv
